// ===== design/hmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// hmmd_pkg
// Shared types, address map constants and the access decode function for the
// handheld memory map decoder.
// ----------------------------------------------------------------------------
package hmmd_pkg;

  // store sizes
  localparam int WORK_BYTES_DEF = 8192;
  localparam int HIGH_BYTES_DEF = 127;
  localparam int IO_BYTES_DEF   = 128;

  // address map
  localparam logic [15:0] CART_LO_END  = 16'h7FFF;
  localparam logic [15:0] VRAM_END     = 16'h9FFF;
  localparam logic [15:0] CART_HI_END  = 16'hBFFF;
  localparam logic [15:0] WRAM_BASE    = 16'hC000;
  localparam logic [15:0] ECHO_END     = 16'hFDFF;
  localparam logic [15:0] OAM_END      = 16'hFE9F;
  localparam logic [15:0] GAP_BASE     = 16'hFEA0;
  localparam logic [15:0] GAP_END      = 16'hFEFF;
  localparam logic [15:0] JOYPAD_ADDR  = 16'hFF00;
  localparam logic [15:0] TIMER_BASE   = 16'hFF04;
  localparam logic [15:0] TIMER_END    = 16'hFF07;
  localparam logic [15:0] IRQ_FLAG_ADR = 16'hFF0F;
  localparam logic [15:0] AUDIO_BASE   = 16'hFF10;
  localparam logic [15:0] AUDIO_END    = 16'hFF3F;
  localparam logic [15:0] VREG_BASE    = 16'hFF40;
  localparam logic [15:0] DMA_ADDR     = 16'hFF46;
  localparam logic [15:0] VREG_END     = 16'hFF4B;
  localparam logic [15:0] IO_BASE      = 16'hFF00;
  localparam logic [15:0] IO_END       = 16'hFF7F;
  localparam logic [15:0] HRAM_BASE    = 16'hFF80;
  localparam logic [15:0] HRAM_END     = 16'hFFFE;
  localparam logic [15:0] IRQ_EN_ADR   = 16'hFFFF;

  localparam logic [7:0]  DMA_MAX_PAGE = 8'hF1;
  localparam logic [7:0]  GAP_READ     = 8'hFF;

  typedef enum logic [1:0] {
    OUT_LOCAL     = 2'd0,
    OUT_EXTERNAL  = 2'd1,
    OUT_DMA_START = 2'd2,
    OUT_DMA_FAULT = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    DEV_NONE   = 3'd0,
    DEV_CART   = 3'd1,
    DEV_VIDEO  = 3'd2,
    DEV_AUDIO  = 3'd3,
    DEV_TIMER  = 3'd4,
    DEV_JOYPAD = 3'd5
  } device_t;

  // where the result byte comes from
  typedef enum logic [2:0] {
    RD_REG  = 3'd0,
    RD_WORK = 3'd1,
    RD_HIGH = 3'd2,
    RD_IO   = 3'd3,
    RD_IF   = 3'd4,
    RD_IE   = 3'd5
  } rd_sel_t;

  typedef struct packed {
    outcome_t    outcome;
    device_t     device;
    logic        req_wr;
    logic [15:0] target;
    logic [7:0]  data;
    rd_sel_t     rd_sel;
    logic        wr_work;
    logic        wr_high;
    logic        wr_io;
    logic        wr_if;
    logic        wr_ie;
  } access_dec_t;

  function automatic access_dec_t decode_access(input logic wr, input logic [15:0] a,
                                                input logic [7:0] d);
    access_dec_t r;
    device_t     dev;
    logic        in_work;
    logic        in_high;
    logic        in_io;
    logic        in_gap;
    r           = '0;
    r.outcome   = OUT_LOCAL;
    r.device    = DEV_NONE;
    r.rd_sel    = RD_REG;

    if (a <= CART_LO_END) begin
      dev = DEV_CART;
    end else if (a <= VRAM_END) begin
      dev = DEV_VIDEO;
    end else if (a <= CART_HI_END) begin
      dev = DEV_CART;
    end else if (a <= ECHO_END) begin
      dev = DEV_NONE;
    end else if (a <= OAM_END) begin
      dev = DEV_VIDEO;
    end else if (a <= GAP_END) begin
      dev = DEV_NONE;
    end else if (a >= AUDIO_BASE && a <= AUDIO_END) begin
      dev = DEV_AUDIO;
    end else if (a >= TIMER_BASE && a <= TIMER_END) begin
      dev = DEV_TIMER;
    end else if (a == DMA_ADDR) begin
      dev = DEV_NONE;
    end else if (a >= VREG_BASE && a <= VREG_END) begin
      dev = DEV_VIDEO;
    end else if (a == JOYPAD_ADDR) begin
      dev = DEV_JOYPAD;
    end else begin
      dev = DEV_NONE;
    end

    in_work = (a >= WRAM_BASE) && (a <= ECHO_END);
    in_high = (a >= HRAM_BASE) && (a <= HRAM_END);
    in_io   = (a >= IO_BASE) && (a <= IO_END) && (a != DMA_ADDR) && (a != IRQ_FLAG_ADR);
    in_gap  = (a >= GAP_BASE) && (a <= GAP_END);

    if (wr && a == DMA_ADDR) begin
      if (d > DMA_MAX_PAGE) begin
        r.outcome = OUT_DMA_FAULT;
      end else begin
        r.outcome = OUT_DMA_START;
        r.target  = {d, 8'h00};
      end
    end else if (dev != DEV_NONE) begin
      r.outcome = OUT_EXTERNAL;
      r.device  = dev;
      r.req_wr  = wr;
      r.target  = a;
      r.data    = wr ? d : 8'h00;
    end else if (wr) begin
      r.wr_work = in_work;
      r.wr_high = in_high;
      r.wr_io   = in_io;
      r.wr_if   = (a == IRQ_FLAG_ADR);
      r.wr_ie   = (a == IRQ_EN_ADR);
    end else if (in_work) begin
      r.rd_sel = RD_WORK;
    end else if (in_high) begin
      r.rd_sel = RD_HIGH;
    end else if (in_io) begin
      r.rd_sel = RD_IO;
    end else if (a == IRQ_FLAG_ADR) begin
      r.rd_sel = RD_IF;
    end else if (a == IRQ_EN_ADR) begin
      r.rd_sel = RD_IE;
    end else if (in_gap) begin
      r.data = GAP_READ;
    end
    return r;
  endfunction

endpackage

// ===== design/handheld_memory_map_decoder_core.sv =====
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_core
// Decodes one bus access per cycle, while busy is low, against the handheld
// memory map, serving work RAM, high RAM, misc I/O and interrupt bytes locally.
// ----------------------------------------------------------------------------
//  channel | ports                                            | transfer when
//  --------+--------------------------------------------------+----------------
//  input   | start, busy, in_opcode, in_address, in_write_data | start & !busy
//  result  | out_valid, out_outcome, out_device,               | out_valid
//          | out_request_is_write, out_target_address,         |
//          | out_data_out                                      |
//
//  one access per cycle while busy is low; its result shows on the cycle after acceptance
//  the result register and the single-port store read set that timing
//  after reset busy stays high while a sweep clears all stores,
//  one entry per cycle
//  the receiver cannot stall, so busy only covers the clearing sweep
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder_core #(
  parameter int WORK_BYTES = hmmd_pkg::WORK_BYTES_DEF,
  parameter int HIGH_BYTES = hmmd_pkg::HIGH_BYTES_DEF,
  parameter int IO_BYTES   = hmmd_pkg::IO_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  output logic [1:0]  out_outcome,
  output logic [2:0]  out_device,
  output logic        out_request_is_write,
  output logic [15:0] out_target_address,
  output logic [7:0]  out_data_out
);

  localparam int WORK_W = $clog2(WORK_BYTES);
  localparam int HIGH_W = $clog2(HIGH_BYTES);
  localparam int IO_W   = $clog2(IO_BYTES);

  logic [7:0] work_mem [WORK_BYTES];
  logic [7:0] high_mem [HIGH_BYTES];
  logic [7:0] io_mem   [IO_BYTES];

  logic              clearing_r;
  logic [WORK_W-1:0] clr_cnt_r;
  logic              clr_last;
  logic              accept;

  hmmd_pkg::access_dec_t dec;
  logic [7:0]            data_nxt;

  logic [7:0]  irq_flag_r;
  logic [7:0]  irq_en_r;
  logic [7:0]  work_rd_r;
  logic [7:0]  high_rd_r;
  logic [7:0]  io_rd_r;

  logic                 valid_r;
  hmmd_pkg::outcome_t   outcome_r;
  hmmd_pkg::device_t    device_r;
  logic                 req_wr_r;
  logic [15:0]          target_r;
  logic [7:0]           data_r;
  hmmd_pkg::rd_sel_t    rd_sel_r;

  assign accept   = start && !clearing_r;
  assign busy     = clearing_r;
  assign clr_last = (clr_cnt_r == WORK_W'(WORK_BYTES - 1));
  assign dec      = hmmd_pkg::decode_access(in_opcode, in_address, in_write_data);

  always_comb begin
    case (dec.rd_sel)
      hmmd_pkg::RD_IF: data_nxt = irq_flag_r;
      hmmd_pkg::RD_IE: data_nxt = irq_en_r;
      default:         data_nxt = dec.data;
    endcase
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + WORK_W'(1);
      if (clr_last) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      work_mem[clr_cnt_r] <= 8'h00;
    end else if (accept && dec.wr_work) begin
      work_mem[in_address[WORK_W-1:0]] <= in_write_data;
    end
    if (accept) begin
      work_rd_r <= work_mem[in_address[WORK_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      if (clr_cnt_r < WORK_W'(HIGH_BYTES)) begin
        high_mem[clr_cnt_r[HIGH_W-1:0]] <= 8'h00;
      end
    end else if (accept && dec.wr_high) begin
      high_mem[in_address[HIGH_W-1:0]] <= in_write_data;
    end
    if (accept) begin
      high_rd_r <= high_mem[in_address[HIGH_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      if (clr_cnt_r < WORK_W'(IO_BYTES)) begin
        io_mem[clr_cnt_r[IO_W-1:0]] <= 8'h00;
      end
    end else if (accept && dec.wr_io) begin
      io_mem[in_address[IO_W-1:0]] <= in_write_data;
    end
    if (accept) begin
      io_rd_r <= io_mem[in_address[IO_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_flag_r <= 8'h00;
      irq_en_r   <= 8'h00;
      valid_r    <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept && dec.wr_if) begin
        irq_flag_r <= in_write_data;
      end
      if (accept && dec.wr_ie) begin
        irq_en_r <= in_write_data;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      outcome_r <= dec.outcome;
      device_r  <= dec.device;
      req_wr_r  <= dec.req_wr;
      target_r  <= dec.target;
      data_r    <= data_nxt;
      rd_sel_r  <= dec.rd_sel;
    end
  end

  always_comb begin
    case (rd_sel_r)
      hmmd_pkg::RD_WORK: out_data_out = work_rd_r;
      hmmd_pkg::RD_HIGH: out_data_out = high_rd_r;
      hmmd_pkg::RD_IO:   out_data_out = io_rd_r;
      default:           out_data_out = data_r;
    endcase
  end

  assign out_valid            = valid_r;
  assign out_outcome          = outcome_r;
  assign out_device           = device_r;
  assign out_request_is_write = req_wr_r;
  assign out_target_address   = target_r;

`ifndef SYNTHESIS
  a_valid_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(start && !clearing_r))
    else $error("result strobe without an accepted access");

  a_non_ext_no_device: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && outcome_r != hmmd_pkg::OUT_EXTERNAL) |->
      (device_r == hmmd_pkg::DEV_NONE && !req_wr_r))
    else $error("device request on a non-external outcome");

  a_fault_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && outcome_r == hmmd_pkg::OUT_DMA_FAULT) |-> (target_r == 16'h0000))
    else $error("dma fault carries a target address");

  a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> ($past(clr_cnt_r) == WORK_W'(WORK_BYTES - 1)))
    else $error("clearing sweep ended early");
`endif

endmodule

// ===== tb/handheld_memory_map_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_core_test
// Runs reads and writes over the whole handheld memory map and checks every
// decoded result against a local model of the map, its local stores and the
// interrupt registers. Results are matched in order against accepted accesses.
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        OP_READ   = 1'b0;
  localparam logic        OP_WRITE  = 1'b1;
  localparam logic [15:0] ECHO_BASE = 16'hE000;
  localparam int          RAND_ACCESSES = 800;

  typedef struct {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    int          gap;
    bit          drain;
  } bus_access_t;

  typedef struct {
    hmmd_pkg::outcome_t outcome;
    hmmd_pkg::device_t  device;
    logic               req_wr;
    logic [15:0]        target;
    logic [7:0]         data;
  } bus_decode_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic [1:0]  out_outcome;
  logic [2:0]  out_device;
  logic        out_request_is_write;
  logic [15:0] out_target_address;
  logic [7:0]  out_data_out;

  handheld_memory_map_decoder_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_address           (in_address),
    .in_write_data        (in_write_data),
    .out_valid            (out_valid),
    .out_outcome          (out_outcome),
    .out_device           (out_device),
    .out_request_is_write (out_request_is_write),
    .out_target_address   (out_target_address),
    .out_data_out         (out_data_out)
  );

  // shadow copies of the local stores
  logic [7:0] work_mem [hmmd_pkg::WORK_BYTES_DEF];
  logic [7:0] high_mem [hmmd_pkg::HIGH_BYTES_DEF];
  logic [7:0] io_mem [hmmd_pkg::IO_BYTES_DEF];
  logic [7:0] irq_flag;
  logic [7:0] irq_enable;

  bus_access_t access_fifo[$];
  bus_decode_t decode_fifo[$];
  bus_access_t issued;
  bus_decode_t want;
  int          mismatches;
  int          idle_count;
  logic        took;

  always #1 clk = ~clk;

  function automatic bus_decode_t decode_bus_access(input logic wr, input logic [15:0] a,
                                                    input logic [7:0] d);
    bus_decode_t       r;
    hmmd_pkg::device_t dev;
    logic [12:0]       widx;
    r.outcome = hmmd_pkg::OUT_LOCAL;
    r.device  = hmmd_pkg::DEV_NONE;
    r.req_wr  = 1'b0;
    r.target  = 16'h0000;
    r.data    = 8'h00;
    if (a <= hmmd_pkg::CART_LO_END) dev = hmmd_pkg::DEV_CART;
    else if (a <= hmmd_pkg::VRAM_END) dev = hmmd_pkg::DEV_VIDEO;
    else if (a <= hmmd_pkg::CART_HI_END) dev = hmmd_pkg::DEV_CART;
    else if (a <= hmmd_pkg::ECHO_END) dev = hmmd_pkg::DEV_NONE;
    else if (a <= hmmd_pkg::OAM_END) dev = hmmd_pkg::DEV_VIDEO;
    else if (a <= hmmd_pkg::GAP_END) dev = hmmd_pkg::DEV_NONE;
    else if (a >= hmmd_pkg::AUDIO_BASE && a <= hmmd_pkg::AUDIO_END) dev = hmmd_pkg::DEV_AUDIO;
    else if (a >= hmmd_pkg::TIMER_BASE && a <= hmmd_pkg::TIMER_END) dev = hmmd_pkg::DEV_TIMER;
    else if (a == hmmd_pkg::DMA_ADDR) dev = hmmd_pkg::DEV_NONE;
    else if (a >= hmmd_pkg::VREG_BASE && a <= hmmd_pkg::VREG_END) dev = hmmd_pkg::DEV_VIDEO;
    else if (a == hmmd_pkg::JOYPAD_ADDR) dev = hmmd_pkg::DEV_JOYPAD;
    else dev = hmmd_pkg::DEV_NONE;

    // dma write wins over the video register range
    if (wr && a == hmmd_pkg::DMA_ADDR) begin
      if (d > hmmd_pkg::DMA_MAX_PAGE) begin
        r.outcome = hmmd_pkg::OUT_DMA_FAULT;
      end else begin
        r.outcome = hmmd_pkg::OUT_DMA_START;
        r.target  = {d, 8'h00};
      end
    end else if (dev != hmmd_pkg::DEV_NONE) begin
      r.outcome = hmmd_pkg::OUT_EXTERNAL;
      r.device  = dev;
      r.req_wr  = wr;
      r.target  = a;
      r.data    = wr ? d : 8'h00;
    end else if (a >= hmmd_pkg::WRAM_BASE && a <= hmmd_pkg::ECHO_END) begin
      widx = 13'((a >= ECHO_BASE) ? a - ECHO_BASE : a - hmmd_pkg::WRAM_BASE);
      if (wr) work_mem[widx] = d;
      else r.data = work_mem[widx];
    end else if (a == hmmd_pkg::IRQ_FLAG_ADR) begin
      if (wr) irq_flag = d;
      else r.data = irq_flag;
    end else if (a == hmmd_pkg::IRQ_EN_ADR) begin
      if (wr) irq_enable = d;
      else r.data = irq_enable;
    end else if (a >= hmmd_pkg::HRAM_BASE && a <= hmmd_pkg::HRAM_END) begin
      if (wr) high_mem[a[6:0]] = d;
      else r.data = high_mem[a[6:0]];
    end else if (a >= hmmd_pkg::IO_BASE && a <= hmmd_pkg::IO_END &&
                 a != hmmd_pkg::DMA_ADDR) begin
      if (wr) io_mem[a[6:0]] = d;
      else r.data = io_mem[a[6:0]];
    end else if (!wr && a >= hmmd_pkg::GAP_BASE && a <= hmmd_pkg::GAP_END) begin
      r.data = hmmd_pkg::GAP_READ;
    end
    return r;
  endfunction

  task automatic log_miss(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic queue_access(input logic wr, input logic [15:0] a, input logic [7:0] d,
                              input int gap, input bit drain);
    bus_access_t x;
    x.wr    = wr;
    x.addr  = a;
    x.wdata = d;
    x.gap   = gap;
    x.drain = drain;
    access_fifo.push_back(x);
  endtask

  // driver: one transfer per start & !busy, idle gaps before each access
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (access_fifo.size() != 0 && idle_count >= access_fifo[0].gap &&
          !(access_fifo[0].drain && decode_fifo.size() != 0)) begin
        issued = access_fifo.pop_front();
        in_opcode     <= issued.wr;
        in_address    <= issued.addr;
        in_write_data <= issued.wdata;
        start         <= 1'b1;
        idle_count = 0;
      end else begin
        start <= 1'b0;
        idle_count++;
      end
    end
  end

  // monitor: result of an access shows the cycle after its transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (decode_fifo.size() == 0) begin
          log_miss($sformatf("result with nothing outstanding: o=%0d dev=%0d w=%0b t=%h d=%h",
                             out_outcome, out_device, out_request_is_write,
                             out_target_address, out_data_out));
        end else begin
          want = decode_fifo.pop_front();
          if (out_outcome !== want.outcome || out_device !== want.device ||
              out_request_is_write !== want.req_wr || out_target_address !== want.target ||
              out_data_out !== want.data) begin
            log_miss($sformatf({"exp o=%0d dev=%0d w=%0b t=%h d=%h, ",
                                "got o=%0d dev=%0d w=%0b t=%h d=%h"},
                               want.outcome, want.device, want.req_wr, want.target,
                               want.data, out_outcome, out_device, out_request_is_write,
                               out_target_address, out_data_out));
          end
        end
      end
      if (start && !busy) begin
        decode_fifo.push_back(decode_bus_access(in_opcode, in_address, in_write_data));
      end
    end
    took <= rst_n && start && !busy;
  end

  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [15:0] a;
    logic        wr;
    int          pick;
    int          gap;
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = OP_READ;
    in_address    = 16'h0000;
    in_write_data = 8'h00;
    took          = 1'b0;
    mismatches    = 0;
    idle_count    = 0;
    foreach (work_mem[i]) work_mem[i] = 8'h00;
    foreach (high_mem[i]) high_mem[i] = 8'h00;
    foreach (io_mem[i]) io_mem[i] = 8'h00;
    irq_flag   = 8'h00;
    irq_enable = 8'h00;

    // directed: range edges, echo aliasing, gap, dma start and fault
    queue_access(OP_READ,  16'h0000, 8'hFF, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::CART_LO_END, 8'h00, 0, 1'b0);
    queue_access(OP_READ,  16'h8000, 8'h00, 1, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::VRAM_END, 8'hFF, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::CART_HI_END, 8'h00, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::WRAM_BASE, 8'hA5, 2, 1'b0);
    queue_access(OP_READ,  ECHO_BASE, 8'h00, 0, 1'b0);
    queue_access(OP_WRITE, 16'hDFFF, 8'hFF, 0, 1'b0);
    queue_access(OP_READ,  16'hDFFF, 8'h00, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::ECHO_END, 8'h3C, 0, 1'b0);
    queue_access(OP_READ,  16'hDDFF, 8'h00, 3, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::OAM_END, 8'h11, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::GAP_BASE, 8'h22, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::GAP_BASE, 8'h00, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::GAP_END, 8'h00, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::JOYPAD_ADDR, 8'h30, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::TIMER_END, 8'h00, 1, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::IRQ_FLAG_ADR, 8'h1F, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::IRQ_FLAG_ADR, 8'h00, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::AUDIO_END, 8'h80, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::DMA_ADDR, hmmd_pkg::DMA_MAX_PAGE, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::DMA_ADDR, 8'hF2, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::DMA_ADDR, 8'h00, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::VREG_END, 8'h00, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::IO_END, 8'h5A, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::HRAM_END, 8'hC3, 0, 1'b0);
    queue_access(OP_WRITE, hmmd_pkg::IRQ_EN_ADR, 8'hFF, 0, 1'b0);
    queue_access(OP_READ,  hmmd_pkg::IRQ_EN_ADR, 8'h00, 0, 1'b1);

    for (int i = 0; i < RAND_ACCESSES; i++) begin
      pick = $urandom_range(0, 9);
      wr   = 1'($urandom_range(0, 1));
      case (pick)
        0, 1: begin
          a = 16'($urandom_range(0, 16'hFFFF));
        end
        2, 3: begin
          // small pools at the start of work ram and the top of echo so reads hit earlier writes
          a = 16'(($urandom_range(0, 1) ? ECHO_BASE : hmmd_pkg::WRAM_BASE) +
                  ($urandom_range(0, 1) ? $urandom_range(0, 15) :
                                          $urandom_range(16'h1DF0, 16'h1DFF)));
        end
        4: a = 16'(hmmd_pkg::HRAM_BASE + $urandom_range(0, 127));
        5: a = 16'(hmmd_pkg::IO_BASE + $urandom_range(0, 127));
        6: begin
          a  = hmmd_pkg::DMA_ADDR;
          wr = ($urandom_range(0, 3) != 0);
        end
        7: a = 16'(hmmd_pkg::GAP_BASE + $urandom_range(0, 95));
        8: a = $urandom_range(0, 1) ? hmmd_pkg::IRQ_FLAG_ADR : hmmd_pkg::IRQ_EN_ADR;
        default: a = 16'($urandom_range(0, hmmd_pkg::CART_HI_END));
      endcase
      gap = ((i % 100) < 20) ? 0 : $urandom_range(0, 3);
      queue_access(wr, a, 8'($urandom_range(0, 255)), gap, (i % 200) == 100);
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (access_fifo.size() != 0 || start || decode_fifo.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (decode_fifo.size() != 0) begin
      log_miss($sformatf("%0d results never arrived", decode_fifo.size()));
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
